>>> hw/rtl/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types and constants for the ascending exchange sorter.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int DATA_W            = 32;
  localparam int MAX_ITEMS_DEFAULT = 8;

  // Top-level sequencer: collect a set, then stream it out
  typedef enum logic [0:0] {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } aes_state_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the incoming request in the chain
    logic shift;   // move every value one cell toward the head
  } aes_cell_ctrl_t;

endpackage : aes_pkg
`default_nettype wire

>>> hw/rtl/aes_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_if
// Valid/ready channels of the sorter: element input and sorted result output.
// ----------------------------------------------------------------------------
interface aes_in_if;
  import aes_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface : aes_in_if

interface aes_out_if;
  import aes_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_out;
  logic                     overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface : aes_out_if
`default_nettype wire

>>> hw/rtl/aes_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_cell
// One slot of the insertion chain: holds a value, takes the incoming value or
// its left neighbor's value on insert, and its right neighbor's on shift.
// ----------------------------------------------------------------------------
module aes_cell
  import aes_pkg::*;
(
  input  wire logic                     clk,
  input  wire aes_cell_ctrl_t           ctrl,
  input  wire logic                     occupied,
  input  wire logic signed [DATA_W-1:0] ins_value,
  input  wire logic signed [DATA_W-1:0] left_value,
  input  wire logic                     left_take,
  input  wire logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0]      value,
  output logic                          take
);

  // Empty slots act as +infinity; equal values stay ahead of the newcomer
  always_comb begin
    take = !occupied || (ins_value < value);
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.insert && take) begin
      value <= left_take ? left_value : ins_value;
    end
  end

endmodule : aes_cell
`default_nettype wire

>>> hw/rtl/ascending_exchange_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascending_exchange_sorter
// Collects a set of signed elements and returns it in ascending order.
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                              | ends when
//   ---------+-----+--------------------------------------+---------------------
//   items    | in  | value[31:0] signed, last             | request with last
//   results  | out | sorted_value[31:0] signed, last_out, | request with last_out
//            |     | overflow                             |
//
// Cycles: one cycle per element while loading; the chain of MAX_ITEMS cells
//   inserts each element in place in the same cycle it is accepted.
// After the closing element, the head cell streams one result per cycle when
//   ready; no element is accepted until the last result of the set is taken.
// Reset clears the sequencer, fill count and overflow flag; cell contents are
//   left as they are and only filled slots are ever read.
// A stall on results holds the head value and the whole chain.
//
module ascending_exchange_sorter
  import aes_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)(
  input  wire logic  clk,
  input  wire logic  rst,
  aes_in_if.sink     items,
  aes_out_if.source  results
);

  localparam int COUNT_W = $clog2(MAX_ITEMS + 1);

  aes_state_t           state, state_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic                 dropped, dropped_next;
  aes_cell_ctrl_t       ctrl;

  logic signed [DATA_W-1:0] cell_value [MAX_ITEMS];
  logic                     cell_take  [MAX_ITEMS];

  logic in_fire;
  logic out_fire;
  logic full;

  assign in_fire  = items.valid && items.ready;
  assign out_fire = results.valid && results.ready;
  assign full     = (count == COUNT_W'(MAX_ITEMS));

  // --------------------------------------------------------------------------
  // Cell chain: cell 0 is the head (smallest value)
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic                     left_take;
    logic signed [DATA_W-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = items.value;
      assign left_take  = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_take  = cell_take[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    aes_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (COUNT_W'(i) < count),
      .ins_value   (items.value),
      .left_value  (left_value),
      .left_take   (left_take),
      .right_value (right_value),
      .value       (cell_value[i]),
      .take        (cell_take[i])
    );
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_fire && items.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_fire && count == COUNT_W'(1)) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs and bookkeeping
  // --------------------------------------------------------------------------
  always_comb begin
    items.ready   = 1'b0;
    results.valid = 1'b0;
    ctrl          = '0;
    count_next    = count;
    dropped_next  = dropped;
    unique case (state)
      ST_LOAD: begin
        items.ready = 1'b1;
        if (in_fire) begin
          if (full) begin
            // drop the element, remember the loss for the whole set
            dropped_next = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            count_next  = count + COUNT_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        results.valid = 1'b1;
        if (out_fire) begin
          // advance the chain toward the head
          ctrl.shift = 1'b1;
          count_next = count - COUNT_W'(1);
          if (count == COUNT_W'(1)) begin
            dropped_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign results.sorted_value = cell_value[0];
  assign results.last_out     = (count == COUNT_W'(1));
  assign results.overflow     = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> count != '0)
    else $error("draining with an empty chain");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_ITEMS))
    else $error("fill count beyond chain length");

  a_set_restart: assert property (@(posedge clk) disable iff (rst)
    out_fire && results.last_out |=> state == ST_LOAD && count == '0 && !dropped)
    else $error("set not rebuilt from empty after last result");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(items.ready && results.valid))
    else $error("loading and draining at once");

endmodule : ascending_exchange_sorter
`default_nettype wire

>>> tb/sv/aes_sort_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_sort_checker
// Watches both channels of the sorter, predicts the sorted stream of every
// closed set and compares each result request field by field.
// ----------------------------------------------------------------------------
module aes_sort_checker
  import aes_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)(
  input  wire logic clk,
  input  wire logic rst,
  aes_in_if         items,
  aes_out_if        results,
  output int        fail_count,
  output int        pending,
  output int        item_count,
  output int        result_count,
  output int        set_count,
  output int        overflow_set_count
);

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } sorted_result_t;

  // Predicted copy of the set being collected
  logic signed [DATA_W-1:0] held_values [MAX_ITEMS];
  int                       held_count;
  logic                     lost_any;
  sorted_result_t           sorted_backlog [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Sort the kept values ascending (signed, duplicates kept) and queue them
  function automatic void sort_closed_set();
    logic signed [DATA_W-1:0] ordered [MAX_ITEMS];
    logic signed [DATA_W-1:0] cur;
    sorted_result_t           res;
    int                       j;
    for (int i = 0; i < held_count; i++) ordered[i] = held_values[i];
    for (int i = 1; i < held_count; i++) begin
      cur = ordered[i];
      j   = i;
      while (j > 0 && ordered[j-1] > cur) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = cur;
    end
    for (int k = 0; k < held_count; k++) begin
      res.sorted_value = ordered[k];
      res.last_out     = (k == held_count - 1);
      res.overflow     = lost_any;
      sorted_backlog.push_back(res);
    end
    set_count++;
    if (lost_any) overflow_set_count++;
    held_count = 0;
    lost_any   = 1'b0;
  endfunction

  always @(posedge clk) begin
    sorted_result_t want;
    if (rst) begin
      held_count         = 0;
      lost_any           = 1'b0;
      fail_count         = 0;
      item_count         = 0;
      result_count       = 0;
      set_count          = 0;
      overflow_set_count = 0;
      sorted_backlog.delete();
    end else begin
      if (results.valid && results.ready) begin
        result_count++;
        if (sorted_backlog.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    results.sorted_value));
        end else begin
          want = sorted_backlog.pop_front();
          if (results.sorted_value !== want.sorted_value)
            report_mismatch($sformatf("sorted_value %0d, predicted %0d",
                                      results.sorted_value, want.sorted_value));
          if (results.last_out !== want.last_out)
            report_mismatch($sformatf("last_out %b, predicted %b on value %0d",
                                      results.last_out, want.last_out,
                                      want.sorted_value));
          if (results.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, predicted %b on value %0d",
                                      results.overflow, want.overflow,
                                      want.sorted_value));
        end
      end
      if (items.valid && items.ready) begin
        item_count++;
        if (held_count < MAX_ITEMS) begin
          held_values[held_count] = items.value;
          held_count++;
        end else begin
          lost_any = 1'b1;
        end
        if (items.last) sort_closed_set();
      end
    end
    pending = sorted_backlog.size();
  end

endmodule : aes_sort_checker

>>> tb/sv/ascending_exchange_sorter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_exchange_sorter_test
// Drives sets of signed elements into the sorter under several idle and
// stall patterns; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module ascending_exchange_sorter_test;
  import aes_pkg::*;

  localparam int SET_CAP       = MAX_ITEMS_DEFAULT;
  localparam int RANDOM_ITEMS  = 106;
  // Cycles without any accepted request before the run is declared hung;
  // far above the longest stall run that a 59 percent pattern produces.
  localparam int STALL_LIMIT   = 1000;
  // Settle time after the last result, with margin
  localparam int SETTLE_CYCLES = 2 * SET_CAP + 10;

  localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst;

  // Idle pattern of the current phase, in percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  int fail_count;
  int pending;
  int item_count;
  int result_count;
  int set_count;
  int overflow_set_count;

  aes_in_if  in_ch ();
  aes_out_if out_ch ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ascending_exchange_sorter #(
    .MAX_ITEMS (SET_CAP)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch)
  );

  aes_sort_checker #(
    .MAX_ITEMS (SET_CAP)
  ) i_checker (
    .clk                (clk),
    .rst                (rst),
    .items              (in_ch),
    .results            (out_ch),
    .fail_count         (fail_count),
    .pending            (pending),
    .item_count         (item_count),
    .result_count       (result_count),
    .set_count          (set_count),
    .overflow_set_count (overflow_set_count)
  );

  // Result side: drop ready at random according to the phase
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no request accepted for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Phase 0: no idling; 1: sender idles; 2: receiver stalls; 3: both
  task automatic set_phase(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
  endtask

  // Offer one element; hold valid until the sorter takes it. Valid is only
  // lowered for an idle gap, so it never drops and rises in the same step.
  task automatic send_item(input logic signed [DATA_W-1:0] val, input logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= val;
    in_ch.last  <= closes;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Send a whole set; the final element carries last
  task automatic send_set(input logic signed [DATA_W-1:0] vals [$]);
    foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
  endtask

  // Mix extremes, a narrow band that forces duplicates, and full-range values
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return MAX_VAL;
      1:       return MIN_VAL;
      2, 3:    return int'($urandom_range(6)) - 3;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic signed [DATA_W-1:0] set_vals [$];
    int                       set_len;
    int                       random_sent;

    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    in_ch.last   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: lone element closing its own set
    set_phase(0);
    set_vals = '{MAX_VAL};
    send_set(set_vals);

    // Directed: both extremes, zero, small values around zero and a duplicate
    set_vals = '{MAX_VAL, MIN_VAL, 0, -1, 1, -1};
    send_set(set_vals);

    // Directed: exactly full set in descending order, no overflow
    set_vals.delete();
    for (int k = 0; k < SET_CAP; k++) set_vals.push_back((SET_CAP - k) * 1000 - 4000);
    send_set(set_vals);

    // Directed: one element too many; the closing element is dropped but
    // still closes the set, and every result carries overflow
    set_vals.delete();
    for (int k = 0; k < SET_CAP; k++) set_vals.push_back(pick_value());
    set_vals.push_back(MIN_VAL);
    send_set(set_vals);

    // Random sets: mostly within capacity, some past it
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      set_phase(random_sent * 4 / RANDOM_ITEMS);
      if ($urandom_range(99) < 20) set_len = $urandom_range(SET_CAP + 4, SET_CAP + 1);
      else                         set_len = $urandom_range(SET_CAP, 1);
      set_vals.delete();
      for (int k = 0; k < set_len; k++) set_vals.push_back(pick_value());
      send_set(set_vals);
      random_sent += set_len;
    end
    in_ch.valid <= 1'b0;

    // Drain: release the receiver and wait for every predicted result
    recv_stall_pct = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run covered %0d elements in %0d sets, %0d of them past capacity",
             item_count, set_count, overflow_set_count);
    $display("%0d sorted results compared under four idle/stall patterns", result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule : ascending_exchange_sorter_test

>>> ascending_exchange_sorter.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_if.sv
hw/rtl/aes_cell.sv
hw/rtl/ascending_exchange_sorter.sv
tb/sv/aes_sort_checker.sv
tb/sv/ascending_exchange_sorter_test.sv
